### hw/rtl/aabb_pkg.sv
package aabb_pkg;

	// Coordinate and coefficient width, and fraction bits of the fixed-point format.
	localparam int CoordWidth = 32;
	localparam int FracBits = 16;

	// Port widths of the payload and of the configuration registers.
	localparam int FieldW = 32;
	localparam int HalfW = 32;
	localparam int RegW = 2 * HalfW;
	localparam int RegCount = 6;
	localparam int RegIdxW = 3;

	// A full product, and the sum of three products plus a shifted translation.
	localparam int ProdW = 2 * CoordWidth;
	localparam int SumW = ProdW + 2;

	localparam logic [SumW-1:0] RoundHalf = (SumW'(1) << FracBits) >> 1;

	typedef logic signed [CoordWidth-1:0] coord_t;
	typedef logic signed [ProdW-1:0] prod_t;
	typedef logic signed [SumW-1:0] sum_t;

	typedef enum logic [RegIdxW-1:0] {
		RegRowXA = 3'd0,
		RegRowXB = 3'd1,
		RegRowYA = 3'd2,
		RegRowYB = 3'd3,
		RegRowZA = 3'd4,
		RegRowZB = 3'd5
	} cfg_reg_t;

	localparam logic [RegW-1:0] RegReset [RegCount] = '{
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000
	};

endpackage

### hw/rtl/aabb_affine_transform_bounds_core.sv
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   min_x min_y min_z max_x max_y max_z
// output    out        out_valid / out_stall out_min_x .. out_max_z
// config    in         cfg_we                cfg_index, cfg_data (no read-back)
//
// Four register stages: products, per-term min/max, three-term sum, then translation,
// rounding and saturation into the output register.
// A new box may be transferred in every cycle while out_stall is low: one box per cycle.
// Each stage advances when its successor is empty or advancing, so bubbles are
// squeezed out and a stall at the output backs up stage by stage without loss.
// Reset (arst_n low) clears every valid bit and loads the identity transform.

module aabb_affine_transform_bounds_core (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  cfg_we,
	input  logic [aabb_pkg::RegIdxW-1:0]          cfg_index,
	input  logic [aabb_pkg::RegW-1:0]             cfg_data,

	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [aabb_pkg::FieldW-1:0]    min_x,
	input  logic signed [aabb_pkg::FieldW-1:0]    min_y,
	input  logic signed [aabb_pkg::FieldW-1:0]    min_z,
	input  logic signed [aabb_pkg::FieldW-1:0]    max_x,
	input  logic signed [aabb_pkg::FieldW-1:0]    max_y,
	input  logic signed [aabb_pkg::FieldW-1:0]    max_z,

	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [aabb_pkg::FieldW-1:0]    out_min_x,
	output logic signed [aabb_pkg::FieldW-1:0]    out_min_y,
	output logic signed [aabb_pkg::FieldW-1:0]    out_min_z,
	output logic signed [aabb_pkg::FieldW-1:0]    out_max_x,
	output logic signed [aabb_pkg::FieldW-1:0]    out_max_y,
	output logic signed [aabb_pkg::FieldW-1:0]    out_max_z
);

	localparam int Cw = aabb_pkg::CoordWidth;
	localparam int Hw = aabb_pkg::HalfW;
	localparam int Sw = aabb_pkg::SumW;

	// Configuration registers, for the user to write only while the pipeline is idle; the block does not enforce it.
	logic [aabb_pkg::RegW-1:0] regs_q [aabb_pkg::RegCount];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < aabb_pkg::RegCount; i++) begin
				regs_q[i] <= aabb_pkg::RegReset[i];
			end
		end else if (cfg_we) begin
			// Indices beyond the register list are ignored.
			unique case (cfg_index)
				aabb_pkg::RegRowXA: regs_q[0] <= cfg_data;
				aabb_pkg::RegRowXB: regs_q[1] <= cfg_data;
				aabb_pkg::RegRowYA: regs_q[2] <= cfg_data;
				aabb_pkg::RegRowYB: regs_q[3] <= cfg_data;
				aabb_pkg::RegRowZA: regs_q[4] <= cfg_data;
				aabb_pkg::RegRowZB: regs_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Unpack the rows: coef[r][a] multiplies input axis a for output row r.
	aabb_pkg::coord_t coef [3][3];
	aabb_pkg::coord_t trans [3];
	aabb_pkg::coord_t lo [3];
	aabb_pkg::coord_t hi [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			coef[r][0] = regs_q[2*r][Cw-1:0];
			coef[r][1] = regs_q[2*r][Hw+Cw-1:Hw];
			coef[r][2] = regs_q[2*r+1][Cw-1:0];
			trans[r]   = regs_q[2*r+1][Hw+Cw-1:Hw];
		end
		lo[0] = min_x[Cw-1:0];
		lo[1] = min_y[Cw-1:0];
		lo[2] = min_z[Cw-1:0];
		hi[0] = max_x[Cw-1:0];
		hi[1] = max_y[Cw-1:0];
		hi[2] = max_z[Cw-1:0];
	end

	// Each output coordinate is a sum of independent terms, one per input axis, and
	// rounding and saturation are monotonic. The extreme over the eight corners
	// is therefore the sum of the per-term extremes, taken before rounding.
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	assign adv_s4 = !v_s4 || !out_stall;
	assign adv_s3 = !v_s3 || adv_s4;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: both products of every coefficient, one against each box bound.
	aabb_pkg::prod_t plo_s1 [3][3];
	aabb_pkg::prod_t phi_s1 [3][3];

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			for (int r = 0; r < 3; r++) begin
				for (int a = 0; a < 3; a++) begin
					plo_s1[r][a] <= aabb_pkg::prod_t'(coef[r][a] * lo[a]);
					phi_s1[r][a] <= aabb_pkg::prod_t'(coef[r][a] * hi[a]);
				end
			end
		end
	end

	// Stage 2: the smaller and the larger of each pair of products.
	aabb_pkg::prod_t mn_s2 [3][3];
	aabb_pkg::prod_t mx_s2 [3][3];

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			for (int r = 0; r < 3; r++) begin
				for (int a = 0; a < 3; a++) begin
					if (plo_s1[r][a] < phi_s1[r][a]) begin
						mn_s2[r][a] <= plo_s1[r][a];
						mx_s2[r][a] <= phi_s1[r][a];
					end else begin
						mn_s2[r][a] <= phi_s1[r][a];
						mx_s2[r][a] <= plo_s1[r][a];
					end
				end
			end
		end
	end

	// Stage 3: exact three-term sums for the lower and upper bound of each row.
	aabb_pkg::sum_t smn_s3 [3];
	aabb_pkg::sum_t smx_s3 [3];

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			for (int r = 0; r < 3; r++) begin
				smn_s3[r] <= Sw'(mn_s2[r][0]) + Sw'(mn_s2[r][1]) + Sw'(mn_s2[r][2]);
				smx_s3[r] <= Sw'(mx_s2[r][0]) + Sw'(mx_s2[r][1]) + Sw'(mx_s2[r][2]);
			end
		end
	end

	// Stage 4: add the translation and half an LSB, drop the fraction, saturate.
	aabb_pkg::sum_t  rmn [3];
	aabb_pkg::sum_t  rmx [3];
	aabb_pkg::coord_t qmn [3];
	aabb_pkg::coord_t qmx [3];
	aabb_pkg::coord_t res_min_s4 [3];
	aabb_pkg::coord_t res_max_s4 [3];

	function automatic aabb_pkg::coord_t sat_coord(input aabb_pkg::sum_t v);
		aabb_pkg::sum_t sh;
		logic [Sw-Cw:0] top;
		sh = v >>> aabb_pkg::FracBits;
		top = sh[Sw-1:Cw-1];
		if (&top || !(|top)) begin
			sat_coord = sh[Cw-1:0];
		end else if (sh[Sw-1]) begin
			sat_coord = {1'b1, {(Cw-1){1'b0}}};
		end else begin
			sat_coord = {1'b0, {(Cw-1){1'b1}}};
		end
	endfunction

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			rmn[r] = smn_s3[r] + (Sw'(trans[r]) <<< aabb_pkg::FracBits)
				+ aabb_pkg::RoundHalf;
			rmx[r] = smx_s3[r] + (Sw'(trans[r]) <<< aabb_pkg::FracBits)
				+ aabb_pkg::RoundHalf;
			qmn[r] = sat_coord(rmn[r]);
			qmx[r] = sat_coord(rmx[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && v_s3) begin
			for (int r = 0; r < 3; r++) begin
				res_min_s4[r] <= qmn[r];
				res_max_s4[r] <= qmx[r];
			end
		end
	end

	assign out_valid = v_s4;
	assign out_min_x = aabb_pkg::FieldW'(res_min_s4[0]);
	assign out_min_y = aabb_pkg::FieldW'(res_min_s4[1]);
	assign out_min_z = aabb_pkg::FieldW'(res_min_s4[2]);
	assign out_max_x = aabb_pkg::FieldW'(res_max_s4[0]);
	assign out_max_y = aabb_pkg::FieldW'(res_max_s4[1]);
	assign out_max_z = aabb_pkg::FieldW'(res_max_s4[2]);

	// The input is held back only when every stage holds a box.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4))
		else $error("input stalled while the pipeline has a free stage");

	// A box leaving the sum stage must reach the output register.
	a_s3_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && adv_s4) |=> v_s4)
		else $error("box lost between the sum stage and the output");

	// The lower bound never exceeds the upper bound on any axis.
	a_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_min_x <= out_max_x && out_min_y <= out_max_y
			&& out_min_z <= out_max_z))
		else $error("transformed box has its lower bound above its upper bound");

endmodule

### tb/sv/aabb_bounds_checker.sv
module aabb_bounds_checker
	import aabb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [RegIdxW-1:0] cfg_index,
	input  logic [RegW-1:0]   cfg_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  coord_t            min_x,
	input  coord_t            min_y,
	input  coord_t            min_z,
	input  coord_t            max_x,
	input  coord_t            max_y,
	input  coord_t            max_z,
	input  logic              out_valid,
	input  logic              out_stall,
	input  coord_t            out_min_x,
	input  coord_t            out_min_y,
	input  coord_t            out_min_z,
	input  coord_t            out_max_x,
	input  coord_t            out_max_y,
	input  coord_t            out_max_z,
	output int                mismatches,
	output int                boxes_in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ReportLimit = 10;

	typedef logic signed [127:0] wide_t;
	typedef struct packed {
		coord_t [2:0] lo;
		coord_t [2:0] hi;
	} bounds_t;

	localparam wide_t SatHigh = (wide_t'(1) <<< (CoordWidth - 1)) - 1;
	localparam wide_t SatLow = -SatHigh - 1;
	localparam wide_t HalfLsb = (wide_t'(1) <<< FracBits) >>> 1;

	logic [RegW-1:0] xform [RegCount];
	bounds_t expected_bounds [$];
	bounds_t box_in, box_out, want;
	int errors;
	int results_seen;
	string axis_names [3] = '{"x", "y", "z"};

	// One output coordinate: the exact row dot product plus translation, rounded half up
	// to the fixed-point grid and clamped to the coordinate range.
	function automatic coord_t map_axis(int row, coord_t px, coord_t py, coord_t pz);
		coord_t cx, cy, cz, shift;
		wide_t acc;
		cx = xform[2*row][HalfW-1:0];
		cy = xform[2*row][RegW-1:HalfW];
		cz = xform[2*row+1][HalfW-1:0];
		shift = xform[2*row+1][RegW-1:HalfW];
		acc = wide_t'(cx) * wide_t'(px) + wide_t'(cy) * wide_t'(py) + wide_t'(cz) * wide_t'(pz);
		acc = (acc + (wide_t'(shift) <<< FracBits) + HalfLsb) >>> FracBits;
		if (acc > SatHigh)
			return coord_t'(SatHigh);
		if (acc < SatLow)
			return coord_t'(SatLow);
		return coord_t'(acc);
	endfunction

	function automatic bounds_t transformed_bounds(bounds_t box);
		bounds_t res;
		coord_t corner [3];
		coord_t v;
		res = '0;
		for (int c = 0; c < 8; c++) begin
			for (int a = 0; a < 3; a++)
				corner[a] = c[a] ? box.hi[a] : box.lo[a];
			for (int a = 0; a < 3; a++) begin
				v = map_axis(a, corner[0], corner[1], corner[2]);
				if (c == 0 || v < coord_t'(res.lo[a]))
					res.lo[a] = v;
				if (c == 0 || v > coord_t'(res.hi[a]))
					res.hi[a] = v;
			end
		end
		return res;
	endfunction

	task automatic flag(string msg);
		errors++;
		if (errors <= ReportLimit)
			$display("%t checker: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RegCount; i++)
				xform[i] = RegReset[i];
			expected_bounds.delete();
			errors = 0;
			results_seen = 0;
			mismatches <= 0;
			boxes_in_flight <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				box_in.lo = {min_z, min_y, min_x};
				box_in.hi = {max_z, max_y, max_x};
				expected_bounds.push_back(transformed_bounds(box_in));
			end
			if (out_valid && !out_stall) begin
				box_out.lo = {out_min_z, out_min_y, out_min_x};
				box_out.hi = {out_max_z, out_max_y, out_max_x};
				if (expected_bounds.size() == 0) begin
					flag($sformatf("result %0d transferred with no box outstanding",
						results_seen));
				end else begin
					want = expected_bounds.pop_front();
					for (int a = 0; a < 3; a++) begin
						if (want.lo[a] !== box_out.lo[a])
							flag($sformatf("result %0d out_min_%s expected %0d, got %0d",
								results_seen, axis_names[a], coord_t'(want.lo[a]),
								coord_t'(box_out.lo[a])));
						if (want.hi[a] !== box_out.hi[a])
							flag($sformatf("result %0d out_max_%s expected %0d, got %0d",
								results_seen, axis_names[a], coord_t'(want.hi[a]),
								coord_t'(box_out.hi[a])));
					end
				end
				results_seen++;
			end
			if (cfg_we && cfg_index < RegIdxW'(RegCount))
				xform[cfg_index] = cfg_data;
			mismatches <= errors;
			boxes_in_flight <= expected_bounds.size();
		end
	end

endmodule

### tb/sv/tb_aabb_affine_transform_bounds_core.sv
module tb_aabb_affine_transform_bounds_core;
	timeunit 1ns;
	timeprecision 1ps;

	import aabb_pkg::*;

	localparam int ClkPeriod = 10;
	// Four register stages in the core; the pause before a register write and at the
	// end of the run allows a little more than that.
	localparam int Latency = 4;
	localparam int IdlePercent = 38;
	localparam int BoxesPerPhase = 200;
	localparam int RandomPhases = 8;
	// Watchdog limit in time units, far beyond what a correct run needs.
	localparam int RunLimit = 2_000_000;

	// Handy fixed-point values in Q16.16.
	localparam coord_t QMax = 32'sh7fff_ffff;
	localparam coord_t QMin = 32'sh8000_0000;
	localparam coord_t One = 32'sh0001_0000;
	localparam coord_t Half = 32'sh0000_8000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [RegIdxW-1:0] cfg_index = '0;
	logic [RegW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	coord_t min_x = '0;
	coord_t min_y = '0;
	coord_t min_z = '0;
	coord_t max_x = '0;
	coord_t max_y = '0;
	coord_t max_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	coord_t out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z;
	int mismatches;
	int boxes_in_flight;

	// While this is set, neither side of the core inserts gaps or stalls.
	bit steady = 1'b0;
	int boxes_sent = 0;
	int settings_used = 1;

	aabb_affine_transform_bounds_core DUT (.*);

	aabb_bounds_checker checker_i (.*);

	always #(ClkPeriod / 2) clk = ~clk;

	// The result side stalls at random, except during the steady stretch.
	always @(posedge clk)
		out_stall <= !steady && ($urandom_range(99) < IdlePercent);

	// A watchdog in its own process: if the run has not finished by now, something
	// has hung, which counts as a failure.
	initial begin
		#(RunLimit);
		$display("Mismatches found");
		$finish;
	end

	// Offers one box and holds it, unchanged, until the core takes the transfer. A random
	// gap may come first. Valid stays high on return, so that back-to-back boxes keep it
	// high without a glitch; whoever stops sending lowers it.
	task automatic send_box(coord_t lx, coord_t ly, coord_t lz, coord_t hx, coord_t hy,
		coord_t hz);
		while (!steady && $urandom_range(99) < IdlePercent) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		min_x <= lx;
		min_y <= ly;
		min_z <= lz;
		max_x <= hx;
		max_y <= hy;
		max_z <= hz;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		boxes_sent++;
	endtask

	// Stops sending, waits until every box sent has come back, then lets the pipeline
	// settle so that it is truly empty.
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (boxes_in_flight != 0)
			@(posedge clk);
		repeat (Latency + 2)
			@(posedge clk);
	endtask

	// Writes all six transform registers, one per cycle, once the core is idle. The two
	// indexes past the last register are written with junk as well: the core must ignore
	// them.
	task automatic load_transform(logic [RegW-1:0] xa, logic [RegW-1:0] xb,
		logic [RegW-1:0] ya, logic [RegW-1:0] yb, logic [RegW-1:0] za, logic [RegW-1:0] zb);
		logic [RegW-1:0] vals [RegCount];
		vals[RegRowXA] = xa;
		vals[RegRowXB] = xb;
		vals[RegRowYA] = ya;
		vals[RegRowYB] = yb;
		vals[RegRowZA] = za;
		vals[RegRowZB] = zb;
		drain();
		for (int i = 0; i < RegCount; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		for (int i = RegCount; i < (1 << RegIdxW); i++) begin
			cfg_we <= 1'b1;
			cfg_index <= RegIdxW'(i);
			cfg_data <= {$urandom, $urandom};
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// A register holds two fields (coefficients, or a coefficient and a translation): the second-named in the high half.
	function automatic logic [RegW-1:0] coef_pair(coord_t lo, coord_t hi);
		return {hi, lo};
	endfunction

	// Coordinates: mostly moderate values with a fraction, some full-range patterns
	// so that every bit toggles, and some extremes of the format.
	function automatic coord_t rand_coord();
		case ($urandom_range(9))
			0, 1: return $urandom;
			2: begin
				case ($urandom_range(5))
					0: return QMin;
					1: return QMax;
					2: return '0;
					3: return -1;
					4: return One;
					default: return -One;
				endcase
			end
			3, 4, 5, 6: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
			default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
		endcase
	endfunction

	// Coefficients: mostly small factors of magnitude up to two, some extremes and
	// some full-range patterns that drive the sums into saturation.
	function automatic coord_t rand_coeff();
		case ($urandom_range(7))
			0: return $urandom;
			1: begin
				case ($urandom_range(5))
					0: return QMin;
					1: return QMax;
					2: return '0;
					3: return One;
					4: return -One;
					default: return Half;
				endcase
			end
			default: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
		endcase
	endfunction

	// Most boxes are well formed; about one axis in thirteen is left inverted.
	task automatic send_random_box;
		coord_t lo [3];
		coord_t hi [3];
		coord_t tmp;
		for (int a = 0; a < 3; a++) begin
			lo[a] = rand_coord();
			hi[a] = rand_coord();
			if ($urandom_range(99) < 85 && lo[a] > hi[a]) begin
				tmp = lo[a];
				lo[a] = hi[a];
				hi[a] = tmp;
			end
		end
		send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
	endtask

	initial begin
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity transform straight from reset: the box must come back as it went in,
		// with min and max swapped on any axis where the box is inverted.
		send_box('0, '0, '0, '0, '0, '0);
		send_box('0, '0, '0, One, One, One);
		send_box(QMin, QMin, QMin, QMax, QMax, QMax);
		send_box(QMax, QMax, QMax, QMin, QMin, QMin);
		send_box(One, One, One, -One, -One, -One);
		send_box(-One, 2 * One, '0, One, -One, One);
		send_box(1, -1, 32'sh0000_7fff, 3, 1, 32'sh0000_8001);

		// Halves and a quarter as factors with odd inputs, so that the rounding sees exact
		// ties on both signs; two of the translations carry fractions too.
		load_transform(coef_pair(Half, 32'shfffe_8000), coef_pair(32'sh0000_4000, 3 * One),
			coef_pair(Half, Half), coef_pair(-Half, -Half),
			coef_pair(32'sh0000_0001, '0), coef_pair(32'shffff_ffff, 32'sh0000_0001));
		send_box(1, 1, 1, 3, 3, 3);
		send_box(-1, -1, -1, 1, 1, 1);
		send_box(-3, '0, 5, -1, 2, 7);
		send_box(32'sh0001_8001, -32'sh0002_0003, 32'sh0000_4001, 32'sh0003_0005,
			-32'sh0001_0001, 32'sh0000_c003);
		send_box(QMin, QMin, QMin, QMax, QMax, QMax);

		// Coefficients and translations at the ends of the range: nearly every corner
		// overflows, in both directions.
		load_transform(coef_pair(QMax, QMax), coef_pair(QMax, QMax),
			coef_pair(QMin, QMin), coef_pair(QMin, QMin),
			coef_pair(QMax, QMin), coef_pair(QMin, QMax));
		send_box(QMin, QMin, QMin, QMax, QMax, QMax);
		send_box('0, '0, '0, '0, '0, '0);
		send_box('0, '0, '0, One, One, One);
		send_box(QMin, QMin, QMin, QMin, QMin, QMin);
		send_box(QMax, QMax, QMax, QMax, QMax, QMax);
		send_box(-1, -1, -1, 1, 1, 1);

		// Random phases. The first collapses every box onto the translation, at its extremes on
		// x and y; one later phase runs with no gaps or stalls at all to push the
		// pipeline at full rate for a long stretch.
		for (int p = 0; p < RandomPhases; p++) begin
			if (p == 0)
				load_transform(coef_pair('0, '0), coef_pair('0, QMax),
					coef_pair('0, '0), coef_pair('0, QMin),
					coef_pair('0, '0), coef_pair('0, '0));
			else
				load_transform(coef_pair(rand_coeff(), rand_coeff()),
					coef_pair(rand_coeff(), rand_coeff()),
					coef_pair(rand_coeff(), rand_coeff()),
					coef_pair(rand_coeff(), rand_coeff()),
					coef_pair(rand_coeff(), rand_coeff()),
					coef_pair(rand_coeff(), rand_coeff()));
			steady = (p == 3);
			for (int i = 0; i < BoxesPerPhase; i++)
				send_random_box();
			steady = 1'b0;
		end

		drain();
		$display("Sent %0d boxes under %0d transform settings: identity, rounding ties,",
			boxes_sent, settings_used);
		$display("saturating and random coefficients, with inverted boxes and random gaps.");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/aabb_pkg.sv
hw/rtl/aabb_affine_transform_bounds_core.sv
tb/sv/aabb_bounds_checker.sv
tb/sv/tb_aabb_affine_transform_bounds_core.sv
